// ===== hdl/gih_pkg.sv =====
// Package for the group id hash table: widths, status codes and shared structs.
// No dependencies; used by every module under hdl except gih_ram.
package gih_pkg;

	localparam int SLOT_COUNT  = 2048;
	localparam int SLOT_W      = $clog2(SLOT_COUNT);
	localparam int MAX_GROUPS  = 1024;
	localparam int GROUP_W     = $clog2(MAX_GROUPS);
	localparam int COUNT_W     = GROUP_W + 1;
	localparam int SALT_SHIFT  = 48;
	localparam int SALT_W      = 16;
	localparam int HASH_W      = 64;
	localparam int KEY_W       = 64;
	localparam int IDX_W       = 10;
	localparam int STATUS_W    = 2;
	localparam int IN_TDATA_W  = 144;
	localparam int OUT_TDATA_W = 80;
	localparam int OUT_PAD_W   = OUT_TDATA_W - GROUP_W - KEY_W - 1;

	typedef enum logic [STATUS_W-1:0] {
		STAT_FOUND     = 2'd0,
		STAT_CREATED   = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_NOT_ALLOC = 2'd3
	} status_t;

	typedef struct packed {
		logic               valid;
		logic [GROUP_W-1:0] grp;
		logic [SALT_W-1:0]  salt;
	} slot_ent_t;

	localparam int SLOT_ENT_W = $bits(slot_ent_t);

	typedef struct packed {
		logic             knull;
		logic [KEY_W-1:0] key;
	} key_ent_t;

	localparam int KEY_ENT_W = $bits(key_ent_t);

	typedef struct packed {
		status_t            status;
		logic [GROUP_W-1:0] grp;
		logic [KEY_W-1:0]   key;
		logic               knull;
	} res_t;

endpackage

// ===== hdl/group_id_hash_table.sv =====
// Group id hash table top level: slot RAM, group key RAM, probe sequencer, output register.
// Depends on gih_pkg, gih_ram, gih_ctrl and gih_out.
// Readback runs S_RDBK, create at the home slot S_PROBE, then the output register; a home
// match runs S_PROBE, S_KEYCMP; each further slot adds S_PROBE (S_KEYCMP on a salt match).
// Throughput: one item at a time; next beat taken the cycle after the result is handed on.
// Reset: a clearing pass empties the slot table; s_tready stays low meanwhile.
module group_id_hash_table (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [143:0] s_tdata,  // key_hash[63:0], key_value[127:64], key_is_null[128],
	                               // read_index[138:129], zero pad
	input  logic [0:0]   s_tuser,  // command[0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [79:0]  m_tdata,  // group_number[9:0], stored_key[73:10],
	                               // stored_key_null[74], zero pad
	output logic [1:0]   m_tuser   // status[1:0]
);
	import gih_pkg::*;

	logic                  slot_we;
	logic [SLOT_W-1:0]     slot_waddr;
	logic [SLOT_ENT_W-1:0] slot_wdata;
	logic [SLOT_W-1:0]     slot_raddr;
	logic [SLOT_ENT_W-1:0] slot_rdata;
	logic                  key_we;
	logic [GROUP_W-1:0]    key_waddr;
	logic [KEY_ENT_W-1:0]  key_wdata;
	logic [GROUP_W-1:0]    key_raddr;
	logic [KEY_ENT_W-1:0]  key_rdata;
	logic                  res_valid;
	res_t                  res;
	logic                  out_ready;

	gih_ram #(.WIDTH(SLOT_ENT_W), .DEPTH(SLOT_COUNT)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	gih_ram #(.WIDTH(KEY_ENT_W), .DEPTH(MAX_GROUPS)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (key_wdata),
		.raddr (key_raddr),
		.rdata (key_rdata)
	);

	gih_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.cmd         (s_tuser[0]),
		.key_hash    (s_tdata[63:0]),
		.key_value   (s_tdata[127:64]),
		.key_is_null (s_tdata[128]),
		.read_index  (s_tdata[138:129]),
		.slot_we     (slot_we),
		.slot_waddr  (slot_waddr),
		.slot_wdata  (slot_wdata),
		.slot_raddr  (slot_raddr),
		.slot_rdata  (slot_rdata),
		.key_we      (key_we),
		.key_waddr   (key_waddr),
		.key_wdata   (key_wdata),
		.key_raddr   (key_raddr),
		.key_rdata   (key_rdata),
		.res_valid   (res_valid),
		.res         (res),
		.out_ready   (out_ready)
	);

	gih_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.out_ready (out_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

// ===== hdl/gih_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module gih_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/gih_ctrl.sv =====
// Probe sequencer: clears the slot table, walks slots linearly, compares keys,
// appends groups and serves readback. Depends on gih_pkg.
module gih_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    cmd,
	input  logic [63:0]             key_hash,
	input  logic [63:0]             key_value,
	input  logic                    key_is_null,
	input  logic [9:0]              read_index,
	output logic                    slot_we,
	output logic [gih_pkg::SLOT_W-1:0]     slot_waddr,
	output logic [gih_pkg::SLOT_ENT_W-1:0] slot_wdata,
	output logic [gih_pkg::SLOT_W-1:0]     slot_raddr,
	input  logic [gih_pkg::SLOT_ENT_W-1:0] slot_rdata,
	output logic                    key_we,
	output logic [gih_pkg::GROUP_W-1:0]    key_waddr,
	output logic [gih_pkg::KEY_ENT_W-1:0]  key_wdata,
	output logic [gih_pkg::GROUP_W-1:0]    key_raddr,
	input  logic [gih_pkg::KEY_ENT_W-1:0]  key_rdata,
	output logic                    res_valid,
	output gih_pkg::res_t           res,
	input  logic                    out_ready
);
	import gih_pkg::*;

	typedef enum logic [5:0] {
		S_CLEAR  = 6'b000001,
		S_IDLE   = 6'b000010,
		S_PROBE  = 6'b000100,
		S_KEYCMP = 6'b001000,
		S_RDBK   = 6'b010000,
		S_WAIT   = 6'b100000
	} state_t;

	state_t             state_q, state_d;
	logic [SLOT_W-1:0]  clr_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [SLOT_W-1:0]  step_q;
	logic [COUNT_W-1:0] count_q;
	logic [SALT_W-1:0]  salt_q;
	logic [KEY_W-1:0]   key_q;
	logic               null_q;
	logic [GROUP_W-1:0] grp_q;
	logic [IDX_W-1:0]   idx_q;
	res_t               res_q;

	logic      accept;
	logic      create;
	logic      advance;
	logic      at_last;
	logic      is_full;
	logic      salt_eq;
	logic      key_eq;
	logic      idx_ok;
	slot_ent_t rd_ent;
	slot_ent_t wr_ent;
	key_ent_t  rd_key;
	key_ent_t  cur_key;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign rd_ent   = slot_ent_t'(slot_rdata);
	assign rd_key   = key_ent_t'(key_rdata);
	assign cur_key  = '{knull: null_q, key: key_q};
	assign at_last  = (step_q == SLOT_W'(SLOT_COUNT - 1));
	assign is_full  = (count_q == COUNT_W'(MAX_GROUPS));
	assign salt_eq  = (rd_ent.salt == salt_q);
	assign key_eq   = (rd_key == cur_key);
	assign idx_ok   = (COUNT_W'(idx_q) < count_q);

	assign slot_raddr = (state_q == S_IDLE) ? key_hash[SLOT_W-1:0] : SLOT_W'(slot_q + 1'b1);
	assign key_raddr  = (state_q == S_IDLE) ? read_index[GROUP_W-1:0] : rd_ent.grp;

	assign wr_ent     = '{valid: 1'b1, grp: count_q[GROUP_W-1:0], salt: salt_q};
	assign slot_we    = (state_q == S_CLEAR) || create;
	assign slot_waddr = (state_q == S_CLEAR) ? clr_q : slot_q;
	assign slot_wdata = (state_q == S_CLEAR) ? '0 : wr_ent;
	assign key_we     = create;
	assign key_waddr  = count_q[GROUP_W-1:0];
	assign key_wdata  = cur_key;

	always_comb begin
		state_d    = state_q;
		res_valid  = 1'b0;
		create     = 1'b0;
		advance    = 1'b0;
		res.status = STAT_FOUND;
		res.grp    = '0;
		res.key    = '0;
		res.knull  = 1'b0;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == SLOT_W'(SLOT_COUNT - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					state_d = cmd ? S_RDBK : S_PROBE;
				end
			end
			S_PROBE: begin
				if (!rd_ent.valid) begin
					res_valid = 1'b1;
					if (is_full) begin
						res.status = STAT_FULL;
					end else begin
						create     = 1'b1;
						res.status = STAT_CREATED;
						res.grp    = count_q[GROUP_W-1:0];
						res.key    = key_q;
						res.knull  = null_q;
					end
				end else if (salt_eq) begin
					state_d = S_KEYCMP;
				end else if (at_last) begin
					res_valid  = 1'b1;
					res.status = STAT_FULL;
				end else begin
					advance = 1'b1;
				end
			end
			S_KEYCMP: begin
				if (key_eq) begin
					res_valid  = 1'b1;
					res.status = STAT_FOUND;
					res.grp    = grp_q;
					res.key    = rd_key.key;
					res.knull  = rd_key.knull;
				end else if (at_last) begin
					res_valid  = 1'b1;
					res.status = STAT_FULL;
				end else begin
					advance = 1'b1;
					state_d = S_PROBE;
				end
			end
			S_RDBK: begin
				res_valid = 1'b1;
				if (idx_ok) begin
					res.status = STAT_FOUND;
					res.grp    = idx_q[GROUP_W-1:0];
					res.key    = rd_key.key;
					res.knull  = rd_key.knull;
				end else begin
					res.status = STAT_NOT_ALLOC;
				end
			end
			S_WAIT: begin
				res_valid = 1'b1;
				res       = res_q;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (res_valid) begin
			state_d = out_ready ? S_IDLE : S_WAIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= SLOT_W'(clr_q + 1'b1);
			end
			if (create) begin
				count_q <= COUNT_W'(count_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q <= key_hash[SLOT_W-1:0];
			step_q <= '0;
			salt_q <= key_hash[SALT_SHIFT +: SALT_W];
			key_q  <= key_is_null ? '0 : key_value;
			null_q <= key_is_null;
			idx_q  <= read_index;
		end
		if (advance) begin
			slot_q <= SLOT_W'(slot_q + 1'b1);
			step_q <= SLOT_W'(step_q + 1'b1);
		end
		if (state_q == S_PROBE && rd_ent.valid && salt_eq) begin
			grp_q <= rd_ent.grp;
		end
		if (res_valid && !out_ready && state_q != S_WAIT) begin
			res_q <= res;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(MAX_GROUPS))
		else $error("group count above capacity");

	a_create_count: assert property (@(posedge clk) disable iff (!arst_n)
		create |=> count_q == COUNT_W'($past(count_q) + 1'b1))
		else $error("group append did not advance count");

	a_keycmp_entry: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_KEYCMP |-> $past(state_q) == S_PROBE)
		else $error("key compare without slot read");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !out_ready) |=> state_q == S_WAIT)
		else $error("stalled result not held");

endmodule

// ===== hdl/gih_out.sv =====
// Output register for result beats on the master side.
// Depends on gih_pkg.
module gih_out (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                res_valid,
	input  gih_pkg::res_t                       res,
	output logic                                out_ready,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [gih_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic [gih_pkg::STATUS_W-1:0]        m_tuser
);
	import gih_pkg::*;

	logic valid_q;
	res_t data_q;

	assign out_ready = !valid_q || m_tready;
	assign m_tvalid  = valid_q;
	assign m_tdata   = {{OUT_PAD_W{1'b0}}, data_q.knull, data_q.key, data_q.grp};
	assign m_tuser   = data_q.status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_valid && out_ready) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && out_ready) begin
			data_q <= res;
		end
	end

endmodule

// ===== test/tb_group_id_hash_table.sv =====
// Testbench for group_id_hash_table: directed table then random find, create and readback beats,
// checked against fixed results (typed rows) or an in-bench model of the slots and group keys.
// Depends on gih_pkg and the RTL under hdl; needs no files or arguments.
module tb_group_id_hash_table;
	timeunit 1ns;
	timeprecision 1ps;
	import gih_pkg::*;

	localparam int CLK_PERIOD     = 20;
	localparam int RESET_CYCLES   = 6;
	localparam int RANDOM_ITEMS   = 620;
	localparam int LONG_HOLD      = 400;
	localparam int TAIL_CYCLES    = 20;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam bit EXP_TYPED      = 1'b1;
	localparam bit EXP_PRED       = 1'b0;

	localparam logic [63:0] H_MID  = 64'h5555_0000_0000_0555;
	localparam logic [63:0] H_ALT  = 64'hA5A5_0000_0000_0000;
	localparam logic [63:0] H_TOP  = 64'h0000_0000_0000_07FF;
	localparam logic [63:0] K_MARK = 64'hDEAD_BEEF_0BAD_F00D;

	typedef enum bit {
		CMD_LOOKUP   = 1'b0,
		CMD_READBACK = 1'b1
	} cmd_t;

	typedef struct {
		cmd_t               cmd;
		logic [HASH_W-1:0]  hash;
		logic [KEY_W-1:0]   key;
		bit                 knull;
		logic [IDX_W-1:0]   ridx;
	} item_t;

	typedef struct {
		item_t it;
		bit    typed;
		res_t  want;
	} dir_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic [0:0]             s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [1:0]             m_tuser;

	bit                 slot_used [SLOT_COUNT];
	logic [GROUP_W-1:0] slot_grp  [SLOT_COUNT];
	logic [SALT_W-1:0]  slot_salt [SLOT_COUNT];
	logic [KEY_W-1:0]   grp_key   [MAX_GROUPS];
	bit                 grp_null  [MAX_GROUPS];
	int unsigned        grp_count;

	res_t     awaited_results[$];
	item_t    created_keys[$];
	dir_row_t dir_rows[$];

	int errors       = 0;
	int items_sent   = 0;
	int lookups_sent = 0;
	int reads_sent   = 0;
	int results_seen = 0;
	int stat_tally[4];

	group_id_hash_table i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic res_t group_lookup(input item_t it);
		res_t             r;
		logic [KEY_W-1:0] k;
		logic [SALT_W-1:0] salt;
		int unsigned      slot;
		int unsigned      g;
		r = '0;
		if (it.cmd == CMD_READBACK) begin
			if (it.ridx >= grp_count) begin
				r.status = STAT_NOT_ALLOC;
			end else begin
				r.status = STAT_FOUND;
				r.grp    = it.ridx;
				r.key    = grp_key[it.ridx];
				r.knull  = grp_null[it.ridx];
			end
			return r;
		end
		k    = it.knull ? '0 : it.key;
		salt = it.hash[SALT_SHIFT +: SALT_W];
		slot = it.hash[SLOT_W-1:0];
		r.status = STAT_FULL;
		for (int step = 0; step < SLOT_COUNT; step++) begin
			if (!slot_used[slot]) begin
				if (grp_count >= MAX_GROUPS)
					break;
				g = grp_count;
				grp_key[g]      = k;
				grp_null[g]     = it.knull;
				grp_count       = g + 1;
				slot_used[slot] = 1'b1;
				slot_grp[slot]  = g[GROUP_W-1:0];
				slot_salt[slot] = salt;
				r.status = STAT_CREATED;
				r.grp    = g[GROUP_W-1:0];
				r.key    = k;
				r.knull  = it.knull;
				return r;
			end
			g = slot_grp[slot];
			if (slot_salt[slot] == salt && grp_null[g] == it.knull &&
			    (it.knull || grp_key[g] == k)) begin
				r.status = STAT_FOUND;
				r.grp    = g[GROUP_W-1:0];
				r.key    = grp_key[g];
				r.knull  = grp_null[g];
				return r;
			end
			slot = (slot + 1) % SLOT_COUNT;
		end
		return r;
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic item_t random_item();
		item_t it;
		item_t pick;
		int    r;
		it.cmd   = CMD_LOOKUP;
		it.hash  = {$urandom, $urandom};
		it.key   = {$urandom, $urandom};
		it.knull = ($urandom_range(0, 99) < 8);
		it.ridx  = IDX_W'($urandom_range(0, 1023));
		r = $urandom_range(0, 99);
		if (r < 20) begin
			it.cmd = CMD_READBACK;
			if (grp_count > 0 && $urandom_range(0, 3) != 0)
				it.ridx = IDX_W'($urandom_range(0, grp_count - 1));
		end else if (r < 55 && created_keys.size() > 0) begin
			pick     = created_keys[$urandom_range(0, created_keys.size() - 1)];
			it.hash  = pick.hash;
			it.knull = pick.knull;
			if (!pick.knull)
				it.key = pick.key;
		end else if (r < 70 && created_keys.size() > 0) begin
			pick = created_keys[$urandom_range(0, created_keys.size() - 1)];
			it.hash[SLOT_W-1:0] = pick.hash[SLOT_W-1:0];
			if ($urandom_range(0, 1))
				it.hash[SALT_SHIFT +: SALT_W] = pick.hash[SALT_SHIFT +: SALT_W];
		end else if (r < 80) begin
			it.hash[SLOT_W-1:0] = SLOT_W'($urandom_range(0, 31));
		end
		return it;
	endfunction

	task automatic add_row(input cmd_t cmd, input logic [63:0] hash, input logic [63:0] key,
	                       input bit knull, input logic [IDX_W-1:0] ridx, input bit typed,
	                       input status_t st, input logic [GROUP_W-1:0] grp,
	                       input logic [63:0] skey, input bit snull);
		dir_row_t row;
		row.it.cmd     = cmd;
		row.it.hash    = hash;
		row.it.key     = key;
		row.it.knull   = knull;
		row.it.ridx    = ridx;
		row.typed      = typed;
		row.want       = '0;
		row.want.status = st;
		row.want.grp   = grp;
		row.want.key   = skey;
		row.want.knull = snull;
		dir_rows.insert(dir_rows.size(), row);
	endtask

	task automatic send_item(input item_t it, input bit typed, input res_t want);
		res_t pred;
		int   gap;
		s_tdata  <= {{(IN_TDATA_W - 139){1'b0}}, it.ridx, it.knull, it.key, it.hash};
		s_tuser  <= it.cmd;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pred = group_lookup(it);
		awaited_results.insert(awaited_results.size(), typed ? want : pred);
		if (pred.status == STAT_CREATED)
			created_keys.insert(created_keys.size(), it);
		items_sent++;
		if (it.cmd == CMD_READBACK)
			reads_sent++;
		else
			lookups_sent++;
		gap = ((items_sent / 40) % 4 == 1) ? 0 : idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		item_t it;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		grp_count = 0;
		foreach (stat_tally[i])
			stat_tally[i] = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		add_row(CMD_READBACK, '1, '1, 1, 0, EXP_TYPED, STAT_NOT_ALLOC, 0, '0, 0);
		add_row(CMD_READBACK, '0, '0, 0, '1, EXP_TYPED, STAT_NOT_ALLOC, 0, '0, 0);
		add_row(CMD_LOOKUP, '0, '0, 0, '1, EXP_TYPED, STAT_CREATED, 0, '0, 0);
		add_row(CMD_LOOKUP, '1, '1, 0, 0, EXP_TYPED, STAT_CREATED, 1, '1, 0);
		add_row(CMD_LOOKUP, H_MID, '1, 1, 0, EXP_TYPED, STAT_CREATED, 2, '0, 1);
		add_row(CMD_LOOKUP, '0, '0, 0, 0, EXP_TYPED, STAT_FOUND, 0, '0, 0);
		add_row(CMD_LOOKUP, H_MID, K_MARK, 1, 0, EXP_TYPED, STAT_FOUND, 2, '0, 1);
		add_row(CMD_LOOKUP, '0, 1, 0, 0, EXP_PRED, STAT_FOUND, 0, '0, 0);
		add_row(CMD_LOOKUP, '0, 1, 0, 0, EXP_PRED, STAT_FOUND, 0, '0, 0);
		add_row(CMD_LOOKUP, H_ALT, '0, 0, 0, EXP_PRED, STAT_FOUND, 0, '0, 0);
		add_row(CMD_LOOKUP, '0, '0, 1, 0, EXP_PRED, STAT_FOUND, 0, '0, 0);
		add_row(CMD_LOOKUP, H_MID, '0, 0, 0, EXP_PRED, STAT_FOUND, 0, '0, 0);
		add_row(CMD_LOOKUP, H_TOP, K_MARK, 0, 0, EXP_PRED, STAT_FOUND, 0, '0, 0);
		add_row(CMD_LOOKUP, H_TOP, K_MARK, 0, 0, EXP_PRED, STAT_FOUND, 0, '0, 0);
		add_row(CMD_LOOKUP, '1, '1, 0, '1, EXP_TYPED, STAT_FOUND, 1, '1, 0);
		add_row(CMD_READBACK, '1, '0, 1, 1, EXP_TYPED, STAT_FOUND, 1, '1, 0);
		add_row(CMD_READBACK, '0, '1, 0, 2, EXP_TYPED, STAT_FOUND, 2, '0, 1);
		add_row(CMD_READBACK, H_ALT, K_MARK, 0, 8, EXP_PRED, STAT_FOUND, 0, '0, 0);
		add_row(CMD_READBACK, H_TOP, '1, 1, 7, EXP_PRED, STAT_FOUND, 0, '0, 0);
		add_row(CMD_LOOKUP, '1, '0, 1, 0, EXP_PRED, STAT_FOUND, 0, '0, 0);

		foreach (dir_rows[i])
			send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

		for (int i = 0; i < RANDOM_ITEMS; i++)
			send_item(random_item(), EXP_PRED, '0);

		drain_results();
		it      = random_item();
		it.cmd  = CMD_READBACK;
		it.ridx = '1;
		send_item(it, EXP_PRED, '0);

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d beats sent (%0d lookups, %0d readbacks), %0d results checked",
		         items_sent, lookups_sent, reads_sent, results_seen);
		$display("groups %0d of %0d; found %0d, created %0d, full %0d, unallocated %0d",
		         grp_count, MAX_GROUPS, stat_tally[STAT_FOUND], stat_tally[STAT_CREATED],
		         stat_tally[STAT_FULL], stat_tally[STAT_NOT_ALLOC]);
		if (errors == 0)
			$display("tb_group_id_hash_table passed");
		else
			$display("tb_group_id_hash_table failed");
		$finish;
	end

	initial begin
		res_t got;
		res_t want;
		int   hold_left;
		bit   long_hold_done;
		bit   burst;
		hold_left      = 0;
		long_hold_done = 1'b0;
		m_tready       = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.status = status_t'(m_tuser);
				got.grp    = m_tdata[GROUP_W-1:0];
				got.key    = m_tdata[GROUP_W +: KEY_W];
				got.knull  = m_tdata[GROUP_W + KEY_W];
				results_seen++;
				if (awaited_results.size() == 0) begin
					errors++;
					$display("%0t: result with nothing expected, status %0d group %0d",
					         $time, got.status, got.grp);
				end else begin
					want = awaited_results.pop_front();
					stat_tally[want.status]++;
					if (got.status !== want.status) begin
						errors++;
						$display("%0t: status expected %0d got %0d", $time, want.status,
						         got.status);
					end
					if (got.grp !== want.grp) begin
						errors++;
						$display("%0t: group_number expected %0d got %0d", $time, want.grp,
						         got.grp);
					end
					if (got.key !== want.key) begin
						errors++;
						$display("%0t: stored_key expected %h got %h", $time, want.key,
						         got.key);
					end
					if (got.knull !== want.knull) begin
						errors++;
						$display("%0t: stored_key_null expected %0d got %0d", $time,
						         want.knull, got.knull);
					end
				end
			end
			burst = ((results_seen / 50) % 3 == 0);
			if (!long_hold_done && results_seen >= 150) begin
				hold_left      = LONG_HOLD;
				long_hold_done = 1'b1;
			end else if (hold_left == 0 && !burst && $urandom_range(0, 99) < 30) begin
				hold_left = idle_len();
			end
			m_tready <= (hold_left == 0);
			if (hold_left > 0)
				hold_left--;
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("tb_group_id_hash_table failed");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/gih_pkg.sv
hdl/gih_ram.sv
hdl/gih_ctrl.sv
hdl/gih_out.sv
hdl/group_id_hash_table.sv
test/tb_group_id_hash_table.sv
